// ===== rtl/core/dpbp_pkg.sv =====
// Shared widths, register codes and payload types of the depth back-projection core.
`default_nettype none

package dpbp_pkg;

   localparam int COORD_BITS = 12;
   localparam int DEPTH_W    = 16;
   localparam int CFG_W      = 16;
   localparam int COLOUR_W   = 8;
   localparam int POINT_W    = 24;

   // pixel index scaled by 16 to line up with the Q12.4 centre
   localparam int PIX_SH_W   = COORD_BITS + 4;
   localparam int DIFF_W     = ((PIX_SH_W > CFG_W) ? PIX_SH_W : CFG_W) + 1;
   localparam int PROD_W     = DIFF_W + DEPTH_W;
   localparam int MAG_W      = PROD_W - 1;
   localparam int HI_W       = MAG_W - POINT_W;
   localparam int DIV_STEPS  = POINT_W;
   // diff, product, magnitude, overflow check, divider steps, saturation
   localparam int PIPE_DEPTH = DIV_STEPS + 5;

   localparam int ADDR_W     = 4;
   localparam int DATA_W     = 32;

   localparam logic [CFG_W-1:0] FOCAL_X_RESET  = 16'd8400;
   localparam logic [CFG_W-1:0] FOCAL_Y_RESET  = 16'd8400;
   localparam logic [CFG_W-1:0] CENTER_X_RESET = 16'd5120;
   localparam logic [CFG_W-1:0] CENTER_Y_RESET = 16'd3840;

   localparam logic signed [POINT_W-1:0] POINT_MAX = {1'b0, {(POINT_W-1){1'b1}}};
   localparam logic signed [POINT_W-1:0] POINT_MIN = {1'b1, {(POINT_W-1){1'b0}}};

   typedef enum logic [1:0] {
      REG_FOCAL_X  = 2'd0,
      REG_FOCAL_Y  = 2'd1,
      REG_CENTER_X = 2'd2,
      REG_CENTER_Y = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [CFG_W-1:0] focal_x;
      logic [CFG_W-1:0] focal_y;
      logic [CFG_W-1:0] center_x;
      logic [CFG_W-1:0] center_y;
   } cfg_type;

   typedef struct packed {
      logic [DEPTH_W-1:0]  depth;
      logic [COLOUR_W-1:0] red;
      logic [COLOUR_W-1:0] green;
      logic [COLOUR_W-1:0] blue;
   } side_type;

   typedef struct packed {
      logic signed [POINT_W-1:0] point_x;
      logic signed [POINT_W-1:0] point_y;
      logic [DEPTH_W-1:0]        point_z;
      logic                      valid_res;
      logic [COLOUR_W-1:0]       red;
      logic [COLOUR_W-1:0]       green;
      logic [COLOUR_W-1:0]       blue;
   } rsp_item_type;

endpackage

`default_nettype wire

// ===== rtl/core/dpbp_csr.sv =====
// Camera intrinsics register file behind the APB-style port.
`default_nettype none

module dpbp_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [dpbp_pkg::ADDR_W-1:0]   paddr,
   input  wire logic [dpbp_pkg::DATA_W-1:0]   pwdata,
   output logic      [dpbp_pkg::DATA_W-1:0]   prdata,
   output logic                               pready,
   output dpbp_pkg::cfg_type                  cfg
);

   dpbp_pkg::cfg_type       cfg_ff;
   dpbp_pkg::cfg_type       cfg_in;
   dpbp_pkg::reg_index_type idx;
   logic                    wr;
   logic [dpbp_pkg::CFG_W-1:0] rd_val;

   assign idx    = dpbp_pkg::reg_index_type'(paddr[3:2]);
   assign wr     = psel & penable & pwrite;
   assign pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (idx)
            dpbp_pkg::REG_FOCAL_X:  cfg_in.focal_x  = pwdata[dpbp_pkg::CFG_W-1:0];
            dpbp_pkg::REG_FOCAL_Y:  cfg_in.focal_y  = pwdata[dpbp_pkg::CFG_W-1:0];
            dpbp_pkg::REG_CENTER_X: cfg_in.center_x = pwdata[dpbp_pkg::CFG_W-1:0];
            dpbp_pkg::REG_CENTER_Y: cfg_in.center_y = pwdata[dpbp_pkg::CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.focal_x  <= dpbp_pkg::FOCAL_X_RESET;
         cfg_ff.focal_y  <= dpbp_pkg::FOCAL_Y_RESET;
         cfg_ff.center_x <= dpbp_pkg::CENTER_X_RESET;
         cfg_ff.center_y <= dpbp_pkg::CENTER_Y_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (idx)
         dpbp_pkg::REG_FOCAL_X:  rd_val = cfg_ff.focal_x;
         dpbp_pkg::REG_FOCAL_Y:  rd_val = cfg_ff.focal_y;
         dpbp_pkg::REG_CENTER_X: rd_val = cfg_ff.center_x;
         dpbp_pkg::REG_CENTER_Y: rd_val = cfg_ff.center_y;
         default:                rd_val = '0;
      endcase
   end

   assign prdata = dpbp_pkg::DATA_W'(rd_val);
   assign cfg    = cfg_ff;

endmodule

`default_nettype wire

// ===== rtl/core/dpbp_axis.sv =====
// One projection axis: offset, multiply by depth, pipelined restoring divide, saturate.
`default_nettype none

module dpbp_axis (
   input  wire logic                                   clock,
   input  wire logic                                   en,
   input  wire logic        [dpbp_pkg::COORD_BITS-1:0] pix,
   input  wire logic        [dpbp_pkg::CFG_W-1:0]      centre,
   input  wire logic        [dpbp_pkg::CFG_W-1:0]      focal,
   input  wire logic        [dpbp_pkg::DEPTH_W-1:0]    depth,
   output logic signed      [dpbp_pkg::POINT_W-1:0]    coord
);

   localparam int DIFF_W  = dpbp_pkg::DIFF_W;
   localparam int PROD_W  = dpbp_pkg::PROD_W;
   localparam int MAG_W   = dpbp_pkg::MAG_W;
   localparam int POINT_W = dpbp_pkg::POINT_W;
   localparam int CFG_W   = dpbp_pkg::CFG_W;
   localparam int STEPS   = dpbp_pkg::DIV_STEPS;

   // stage 1: signed offset from the principal point
   logic signed [DIFF_W-1:0]           diff_in, diff_ff;
   logic        [dpbp_pkg::DEPTH_W-1:0] depth_ff;

   assign diff_in = $signed(DIFF_W'({pix, 4'b0000})) - $signed(DIFF_W'(centre));

   always_ff @(posedge clock) begin
      if (en) begin
         diff_ff  <= diff_in;
         depth_ff <= depth;
      end
   end

   // stage 2: exact numerator
   logic signed [PROD_W:0]   prod_full;
   logic signed [PROD_W-1:0] prod_ff;

   assign prod_full = diff_ff * $signed({1'b0, depth_ff});

   always_ff @(posedge clock) begin
      if (en) prod_ff <= prod_full[PROD_W-1:0];
   end

   // stage 3: sign and magnitude, so the divider truncates toward zero
   logic signed [PROD_W-1:0] prod_neg;
   logic        [MAG_W-1:0]  mag_in, mag_ff;
   logic                     neg_m_ff, nz_m_ff;

   assign prod_neg = -prod_ff;
   assign mag_in   = prod_ff[PROD_W-1] ? prod_neg[MAG_W-1:0] : prod_ff[MAG_W-1:0];

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff   <= mag_in;
         neg_m_ff <= prod_ff[PROD_W-1];
         nz_m_ff  <= |prod_ff;
      end
   end

   // stage 4: the quotient leaves 24 bits when the upper part reaches the divisor;
   // a zero focal length always lands here
   logic [CFG_W-1:0]   hi_ext;
   logic [CFG_W-1:0]   rem_ff  [0:STEPS];
   logic [POINT_W-1:0] work_ff [0:STEPS];
   logic               neg_ff  [0:STEPS];
   logic               nz_ff   [0:STEPS];
   logic               ovf_ff  [0:STEPS];

   assign hi_ext = CFG_W'(mag_ff[MAG_W-1:POINT_W]);

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= hi_ext;
         work_ff[0] <= mag_ff[POINT_W-1:0];
         neg_ff[0]  <= neg_m_ff;
         nz_ff[0]   <= nz_m_ff;
         ovf_ff[0]  <= (hi_ext >= focal);
      end
   end

   // one quotient bit per stage; the work word shifts dividend bits out and
   // quotient bits in
   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic [CFG_W:0] trial;
      logic [CFG_W:0] sub;
      logic           take;

      assign trial = {rem_ff[k], work_ff[k][POINT_W-1]};
      assign sub   = trial - {1'b0, focal};
      assign take  = (trial >= {1'b0, focal});

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1]  <= take ? sub[CFG_W-1:0] : trial[CFG_W-1:0];
            work_ff[k+1] <= {work_ff[k][POINT_W-2:0], take};
            neg_ff[k+1]  <= neg_ff[k];
            nz_ff[k+1]   <= nz_ff[k];
            ovf_ff[k+1]  <= ovf_ff[k];
         end
      end
   end

   // final stage: apply sign and clamp
   logic        [POINT_W-1:0] quo;
   logic        [POINT_W-1:0] quo_neg;
   logic signed [POINT_W-1:0] coord_in, coord_ff;

   assign quo     = work_ff[STEPS];
   assign quo_neg = ~quo + 1'b1;

   always_comb begin
      if (!nz_ff[STEPS]) begin
         coord_in = '0;
      end else if (ovf_ff[STEPS]) begin
         coord_in = neg_ff[STEPS] ? dpbp_pkg::POINT_MIN : dpbp_pkg::POINT_MAX;
      end else if (!neg_ff[STEPS]) begin
         coord_in = quo[POINT_W-1] ? dpbp_pkg::POINT_MAX : $signed(quo);
      end else if (quo[POINT_W-1] && (|quo[POINT_W-2:0])) begin
         coord_in = dpbp_pkg::POINT_MIN;
      end else begin
         coord_in = $signed(quo_neg);
      end
   end

   always_ff @(posedge clock) begin
      if (en) coord_ff <= coord_in;
   end

   assign coord = coord_ff;

endmodule

`default_nettype wire

// ===== rtl/core/dpbp_skid.sv =====
// Two-entry output buffer: output register plus skid register.
`default_nettype none

module dpbp_skid (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   input  wire dpbp_pkg::rsp_item_type in_item,
   output logic                        full,
   output logic                        out_valid,
   input  wire logic                   out_stall,
   output dpbp_pkg::rsp_item_type      out_item
);

   logic                   out_v_ff, out_v_in;
   logic                   skid_v_ff, skid_v_in;
   dpbp_pkg::rsp_item_type out_ff, out_in;
   dpbp_pkg::rsp_item_type skid_ff, skid_in;
   logic                   push, pop;

   // upstream only pushes while the skid slot is free
   assign push = in_valid & ~skid_v_ff;
   assign pop  = out_v_ff & ~out_stall;

   always_comb begin
      out_v_in  = out_v_ff;
      skid_v_in = skid_v_ff;
      out_in    = out_ff;
      skid_in   = skid_ff;
      if (skid_v_ff) begin
         if (pop) begin
            out_in    = skid_ff;
            out_v_in  = 1'b1;
            skid_v_in = 1'b0;
         end
      end else if (!out_v_ff || pop) begin
         out_in   = in_item;
         out_v_in = push;
      end else if (push) begin
         skid_in   = in_item;
         skid_v_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_v_ff;
   assign out_valid = out_v_ff;
   assign out_item  = out_ff;

endmodule

`default_nettype wire

// ===== rtl/core/depth_pixel_back_projection_core.sv =====
// Top level of the depth pixel back-projection core.
// Takes one depth pixel per clock while req_stall is low and returns one camera-frame
// point per pixel through five arithmetic stages around a 24-stage restoring divider,
// one quotient bit per stage for each axis, followed by the output register.
// The whole pipeline advances together; a two-entry output buffer lets it keep
// taking pixels while a result waits, and req_stall rises only once that buffer
// is full. x and y are clamped to signed 24 bits; zero depth gives a zero point
// with valid_res low and the colour bytes passed through. Write the intrinsics
// only while no pixel is in flight.
`default_nettype none

module depth_pixel_back_projection_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // pixel stream in
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [dpbp_pkg::COORD_BITS-1:0]     req_column,
   input  wire logic [dpbp_pkg::COORD_BITS-1:0]     req_row,
   input  wire logic [dpbp_pkg::DEPTH_W-1:0]        req_depth,
   input  wire logic [dpbp_pkg::COLOUR_W-1:0]       req_in_red,
   input  wire logic [dpbp_pkg::COLOUR_W-1:0]       req_in_green,
   input  wire logic [dpbp_pkg::COLOUR_W-1:0]       req_in_blue,
   // point stream out
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [dpbp_pkg::POINT_W-1:0]      rsp_point_x,
   output logic signed [dpbp_pkg::POINT_W-1:0]      rsp_point_y,
   output logic [dpbp_pkg::DEPTH_W-1:0]             rsp_point_z,
   output logic                                     rsp_valid_res,
   output logic [dpbp_pkg::COLOUR_W-1:0]            rsp_out_red,
   output logic [dpbp_pkg::COLOUR_W-1:0]            rsp_out_green,
   output logic [dpbp_pkg::COLOUR_W-1:0]            rsp_out_blue,
   // register port
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [dpbp_pkg::ADDR_W-1:0]         paddr,
   input  wire logic [dpbp_pkg::DATA_W-1:0]         pwdata,
   output logic [dpbp_pkg::DATA_W-1:0]              prdata,
   output logic                                     pready
);

   localparam int DEPTH = dpbp_pkg::PIPE_DEPTH;

   dpbp_pkg::cfg_type      cfg;
   dpbp_pkg::rsp_item_type item;
   dpbp_pkg::rsp_item_type out_item;
   dpbp_pkg::side_type     side_ff [0:DEPTH-1];
   logic                   vld_ff  [0:DEPTH-1];
   logic                   full;
   logic                   en;
   logic signed [dpbp_pkg::POINT_W-1:0] coord_x, coord_y;

   dpbp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign en        = ~full;
   assign req_stall = full;

   dpbp_axis u_axis_x (
      .clock  (clock),
      .en     (en),
      .pix    (req_column),
      .centre (cfg.center_x),
      .focal  (cfg.focal_x),
      .depth  (req_depth),
      .coord  (coord_x)
   );

   dpbp_axis u_axis_y (
      .clock  (clock),
      .en     (en),
      .pix    (req_row),
      .centre (cfg.center_y),
      .focal  (cfg.focal_y),
      .depth  (req_depth),
      .coord  (coord_y)
   );

   // valid bits and pass-through fields ride alongside the arithmetic
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) vld_ff[i] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i < DEPTH; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= '{depth: req_depth, red: req_in_red,
                         green: req_in_green, blue: req_in_blue};
         for (int i = 1; i < DEPTH; i++) side_ff[i] <= side_ff[i-1];
      end
   end

   always_comb begin
      item.valid_res = |side_ff[DEPTH-1].depth;
      item.point_x   = coord_x;
      item.point_y   = coord_y;
      item.point_z   = side_ff[DEPTH-1].depth;
      item.red       = side_ff[DEPTH-1].red;
      item.green     = side_ff[DEPTH-1].green;
      item.blue      = side_ff[DEPTH-1].blue;
   end

   dpbp_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld_ff[DEPTH-1]),
      .in_item   (item),
      .full      (full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_item  (out_item)
   );

   assign rsp_point_x   = out_item.point_x;
   assign rsp_point_y   = out_item.point_y;
   assign rsp_point_z   = out_item.point_z;
   assign rsp_valid_res = out_item.valid_res;
   assign rsp_out_red   = out_item.red;
   assign rsp_out_green = out_item.green;
   assign rsp_out_blue  = out_item.blue;

endmodule

`default_nettype wire

// ===== rtl/core/dpbp_checker.sv =====
// Port-level checks on the back-projection core, bound to the top level.
`default_nettype none

module dpbp_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_stall,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_stall,
   input wire logic signed [dpbp_pkg::POINT_W-1:0] rsp_point_x,
   input wire logic signed [dpbp_pkg::POINT_W-1:0] rsp_point_y,
   input wire logic [dpbp_pkg::DEPTH_W-1:0]        rsp_point_z,
   input wire logic                                rsp_valid_res,
   input wire logic [dpbp_pkg::COLOUR_W-1:0]       rsp_out_red,
   input wire logic [dpbp_pkg::COLOUR_W-1:0]       rsp_out_green,
   input wire logic [dpbp_pkg::COLOUR_W-1:0]       rsp_out_blue
);

   // a held result keeps every field
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable({rsp_point_x, rsp_point_y,
         rsp_point_z, rsp_valid_res, rsp_out_red, rsp_out_green, rsp_out_blue}))
      else $error("result changed while stalled");

   // a point marked bad carries zero coordinates
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |-> rsp_point_x == 0 && rsp_point_y == 0
         && rsp_point_z == 0)
      else $error("bad point with nonzero coordinates");

   // a good point always has depth
   a_good_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_valid_res |-> rsp_point_z != 0)
      else $error("good point with zero depth");

   // nothing comes out, and nothing is held off, straight after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("transfer state not cleared by reset");

endmodule

bind depth_pixel_back_projection_core dpbp_checker u_dpbp_checker (.*);

`default_nettype wire
